// ===== sv/frame_reassembly_tof_level_calc_top_assert.svh =====
// assertion macros shared by the checker of the level calculator
`ifndef FRAME_REASSEMBLY_TOF_LEVEL_CALC_TOP_ASSERT_SVH
`define FRAME_REASSEMBLY_TOF_LEVEL_CALC_TOP_ASSERT_SVH

// check on every clock edge outside of reset
`define FRTLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define FRTLC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/frtlc_pkg.sv =====
// shared types, constants and helpers of the time-of-flight level calculator
`default_nettype none

package frtlc_pkg;

	// frame codes
	localparam logic [7:0] CODE_START = 8'h10;
	localparam logic [7:0] CODE_FINAL = 8'h15;

	// sample store geometry
	localparam int DATA_PER_FRAME = 7;
	localparam int BUF_BYTES      = 36;
	localparam int BUF_WORDS      = BUF_BYTES / 4;
	localparam int WORD_AW        = $clog2(BUF_WORDS);
	localparam int BIDX_W         = 6;
	localparam int SLOT_W         = 3;
	localparam logic [SLOT_W-1:0] SLOT_MAX = 3'd7;

	// field widths
	localparam int CODE_W  = 8;
	localparam int BYTE_W  = 8;
	localparam int RAW_W   = 32;
	localparam int REG_W   = 24;
	localparam int TIME_W  = 38;
	localparam int LEVEL_W = 32;
	localparam int IDX_W   = 2;
	localparam int S_TDATA_W = CODE_W + DATA_PER_FRAME * BYTE_W;
	localparam int M_FIELDS_W = 3 * TIME_W + LEVEL_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;
	localparam int M_TUSER_W  = IDX_W + 1;

	// serial divider widths: |scale * dT| / |dT|
	localparam int DVD_W     = REG_W + RAW_W;
	localparam int DVS_W     = RAW_W;
	localparam int DIV_CNT_W = $clog2(DVD_W);
	localparam int LVL_WIDE  = DVD_W + 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET0 = 3'd3;

	// register reset values per sensor
	localparam logic [REG_W-1:0] SCALE_RST  [3] = '{24'd239840, 24'd240384, 24'd239552};
	localparam logic [REG_W-1:0] OFFSET_RST [3] = '{24'd496112, 24'd496176, 24'd496192};

	// request to the divider
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	// response from the divider
	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// raw count times 50 as shifts and adds
	function automatic logic [TIME_W-1:0] time_x50(input logic [RAW_W-1:0] raw);
		logic [TIME_W-1:0] r;
		r = TIME_W'(raw);
		return (r << 5) + (r << 4) + (r << 1);
	endfunction

endpackage

`default_nettype wire

// ===== sv/frtlc_buffer.sv =====
// sample store: frame reassembly into nine 32-bit words with slot tracking
`default_nettype none

module frtlc_buffer import frtlc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CODE_W-1:0]     code,
	input  wire logic [BYTE_W-1:0]     data_b [DATA_PER_FRAME],
	output logic                       emit,
	input  wire logic [WORD_AW-1:0]    rd_idx,
	output logic [RAW_W-1:0]           rd_data
);

	logic [RAW_W-1:0]  words_q [BUF_WORDS];
	logic [RAW_W-1:0]  words_d [BUF_WORDS];
	logic [SLOT_W-1:0] slot_q;
	logic              started_q;

	logic              is_start;
	logic              in_range;
	logic              eff_started;
	logic [SLOT_W-1:0] eff_slot;
	logic              do_write;
	logic [BIDX_W-1:0] base;

	// start code restarts at slot zero in the same item
	assign is_start    = (code == CODE_START);
	assign in_range    = (code >= CODE_START) && (code <= CODE_FINAL);
	assign eff_started = started_q | is_start;
	assign eff_slot    = is_start ? '0 : slot_q;
	assign do_write    = wr_en && in_range && eff_started;
	assign emit        = eff_started && (code == CODE_FINAL);
	assign base        = BIDX_W'(eff_slot) * BIDX_W'(DATA_PER_FRAME);

	// byte lanes falling into this slot's window take the payload
	always_comb begin
		logic [BIDX_W-1:0] bidx;
		logic [2:0]        sel;
		for (int w = 0; w < BUF_WORDS; w++) begin
			words_d[w] = words_q[w];
			for (int j = 0; j < 4; j++) begin
				bidx = BIDX_W'(4 * w + j);
				sel  = 3'(bidx - base);
				if (do_write && (bidx >= base) &&
				    (bidx < base + BIDX_W'(DATA_PER_FRAME))) begin
					words_d[w][8*j +: 8] = data_b[sel];
				end
			end
		end
	end

	// store and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < BUF_WORDS; w++) begin
				words_q[w] <= '0;
			end
			slot_q    <= '0;
			started_q <= 1'b0;
		end else if (wr_en) begin
			words_q   <= words_d;
			started_q <= eff_started;
			if (do_write) begin
				slot_q <= (eff_slot < SLOT_MAX) ? eff_slot + 1'b1 : SLOT_MAX;
			end
		end
	end

	// single read port
	assign rd_data = words_q[rd_idx];

endmodule

`default_nettype wire

// ===== sv/frtlc_div.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module frtlc_div import frtlc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVD_W-1:0]     dq_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0]       rem_sh;
	logic [DVS_W+1:0]     diff;
	logic                 ge;

	// trial subtract of the shifted remainder
	assign rem_sh = {rem_q, dq_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = ~diff[DVS_W+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

`default_nettype wire

// ===== sv/frame_reassembly_tof_level_calc_top.sv =====
// top level: frame intake, sensor sequencer, multiply and level saturation
// Takes eight-byte frame payloads (code in s_tdata[7:0], data bytes above it) and
// reassembles a 36-byte sample buffer. Every item other than a final frame (code
// 0x15 after a start) is taken without holding off the next. A final frame yields
// one result per sensor in sensor order, tlast on the last one. Each result goes
// through three word reads, one 24x32 multiply and the 56-step serial divider.
// A final frame thus holds off the next item until the last result of the run is
// loaded into the output register, and longer while a finished result waits because
// the output register still holds an earlier one that is not yet taken. Results
// wait in that output register, so the sequencer runs on while one is not yet
// taken, and the last result of a run may still wait while the next item is accepted.
// Configuration is a plain write port and is meant to be written while idle.
`default_nettype none

module frame_reassembly_tof_level_calc_top import frtlc_pkg::*; #(
	parameter int SENSOR_COUNT = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// frame_code, byte1, byte2, ... byte7
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// time_first, time_second, time_third, level, zero pad
	output logic [M_TDATA_W-1:0]       m_tdata,
	// sensor_index, divide_error
	output logic [M_TUSER_W-1:0]       m_tuser,
	output logic                       m_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [REG_W-1:0]      cfg_data
);

	localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DSTART,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [REG_W-1:0]   scale_q  [SENSOR_COUNT];
	logic [REG_W-1:0]   offset_q [SENSOR_COUNT];

	logic [IDX_W-1:0]   n_q;
	logic [1:0]         k_q;
	logic [RAW_W-1:0]   raw_q [3];
	logic [DVD_W-1:0]   prod_q;
	logic [DVS_W-1:0]   dvs_q;
	logic               neg_q;
	logic               derr_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [TIME_W-1:0]  out_t1_q;
	logic [TIME_W-1:0]  out_t2_q;
	logic [TIME_W-1:0]  out_t3_q;
	logic [LEVEL_W-1:0] out_lvl_q;
	logic               out_derr_q;
	logic               out_last_q;

	logic [BYTE_W-1:0]  data_b [DATA_PER_FRAME];
	logic               accept;
	logic               emit;
	logic [WORD_AW-1:0] rd_idx;
	logic [RAW_W-1:0]   rd_data;

	logic [SIDX_W-1:0]  sidx;
	logic [RAW_W:0]     diff_a;
	logic [RAW_W:0]     diff_b;
	logic [RAW_W-1:0]   amag;
	logic [RAW_W-1:0]   bmag;
	logic [DVD_W-1:0]   prod_c;

	div_req_t           dreq;
	div_rsp_t           drsp;

	logic [DVD_W:0]     q_signed;
	logic [LVL_WIDE-1:0] lvl_wide;
	logic [LEVEL_W-1:0] lvl_sat;
	logic               is_last;
	logic               load_out;

	// payload unpacking
	always_comb begin
		for (int i = 0; i < DATA_PER_FRAME; i++) begin
			data_b[i] = s_tdata[CODE_W + BYTE_W*i +: BYTE_W];
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign sidx     = n_q[SIDX_W-1:0];
	assign is_last  = (n_q == IDX_W'(SENSOR_COUNT - 1));

	// sensor n, time k sits in word 3n+k
	assign rd_idx = (WORD_AW'(n_q) << 1) + WORD_AW'(n_q) + WORD_AW'(k_q);

	frtlc_buffer u_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.code    (s_tdata[CODE_W-1:0]),
		.data_b  (data_b),
		.emit    (emit),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				scale_q[i]  <= SCALE_RST[i];
				offset_q[i] <= OFFSET_RST[i];
			end
		end else if (cfg_we) begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				if (cfg_index == CFG_SCALE0 + CFG_IDX_W'(i)) begin
					scale_q[i] <= cfg_data;
				end
				if (cfg_index == CFG_OFFSET0 + CFG_IDX_W'(i)) begin
					offset_q[i] <= cfg_data;
				end
			end
		end
	end

	// time differences, magnitudes and the scale product
	assign diff_a = {1'b0, raw_q[2]} - {1'b0, raw_q[1]};
	assign diff_b = {1'b0, raw_q[1]} - {1'b0, raw_q[0]};
	assign amag   = diff_a[RAW_W] ? RAW_W'(-diff_a) : diff_a[RAW_W-1:0];
	assign bmag   = diff_b[RAW_W] ? RAW_W'(-diff_b) : diff_b[RAW_W-1:0];
	assign prod_c = DVD_W'(scale_q[sidx]) * DVD_W'(amag);

	// divider request
	assign dreq.start    = (state_q == ST_DSTART);
	assign dreq.dividend = prod_q;
	assign dreq.divisor  = dvs_q;

	frtlc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// signed quotient, level and saturation
	assign q_signed = neg_q ? -{1'b0, drsp.quotient} : {1'b0, drsp.quotient};
	assign lvl_wide = LVL_WIDE'(signed'(offset_q[sidx])) - LVL_WIDE'(signed'(q_signed));
	always_comb begin
		if (!lvl_wide[LVL_WIDE-1] && (lvl_wide[LVL_WIDE-2:LEVEL_W-1] != '0)) begin
			lvl_sat = {1'b0, {(LEVEL_W-1){1'b1}}};
		end else if (lvl_wide[LVL_WIDE-1] && (lvl_wide[LVL_WIDE-2:LEVEL_W-1] != '1)) begin
			lvl_sat = {1'b1, {(LEVEL_W-1){1'b0}}};
		end else begin
			lvl_sat = lvl_wide[LEVEL_W-1:0];
		end
	end

	assign load_out = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			raw_q[k_q] <= rd_data;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_c;
			dvs_q  <= bmag;
			neg_q  <= diff_a[RAW_W] ^ diff_b[RAW_W];
			derr_q <= (diff_b == '0);
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_t1_q    <= '0;
			out_t2_q    <= '0;
			out_t3_q    <= '0;
			out_lvl_q   <= '0;
			out_derr_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_idx_q   <= n_q;
				out_t1_q    <= time_x50(raw_q[0]);
				out_t2_q    <= time_x50(raw_q[1]);
				out_t3_q    <= time_x50(raw_q[2]);
				out_lvl_q   <= derr_q ? '0 : lvl_sat;
				out_derr_q  <= derr_q;
				out_last_q  <= is_last;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && emit) begin
						n_q     <= '0;
						k_q     <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (k_q == 2'd2) begin
						state_q <= ST_MUL;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (drsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							n_q     <= n_q + 1'b1;
							k_q     <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_lvl_q, out_t3_q, out_t2_q, out_t1_q};
	assign m_tuser  = {out_derr_q, out_idx_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== sv/frtlc_chk.sv =====
// port-level checker of the level calculator and its bind
`default_nettype none

`include "frame_reassembly_tof_level_calc_top_assert.svh"

module frtlc_chk import frtlc_pkg::*; #(
	parameter int SENSOR_COUNT = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tready,
	input  wire logic [M_TDATA_W-1:0]  m_tdata,
	input  wire logic [M_TUSER_W-1:0]  m_tuser,
	input  wire logic                  m_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready
);

	// no result shows once reset has been seen
	`FRTLC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_tvalid, "result valid during reset")

	// a stalled result holds its payload
	`FRTLC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// a divide error result carries a zero level
	`FRTLC_ASSERT(a_derr_level, m_tvalid && m_tuser[IDX_W] |-> m_tdata[M_FIELDS_W-1:3*TIME_W] == '0, "divide error with nonzero level")

	// the last result belongs to the final sensor
	`FRTLC_ASSERT(a_last_index, m_tvalid && m_tlast |-> m_tuser[IDX_W-1:0] == IDX_W'(SENSOR_COUNT - 1), "last flag on wrong sensor")

	// after a non-final result is taken the run goes on before new input
	`FRTLC_ASSERT(a_run_busy, m_tvalid && m_tready && !m_tlast |=> m_tvalid || !s_tready, "input taken inside a run")

endmodule

bind frame_reassembly_tof_level_calc_top frtlc_chk #(.SENSOR_COUNT(SENSOR_COUNT)) u_chk (.*);

`default_nettype wire

// ===== tb/frame_reassembly_tof_level_calc_checker.sv =====
// checker for the level calculator: watches the channels, predicts the results and compares
`timescale 1ns / 1ps

module frame_reassembly_tof_level_calc_checker import frtlc_pkg::*; #(
	parameter int SENSOR_COUNT = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// frame_code, byte1, byte2, ... byte7
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	// time_first, time_second, time_third, level, zero pad
	input  wire logic [M_TDATA_W-1:0]  m_tdata,
	// sensor_index, divide_error
	input  wire logic [M_TUSER_W-1:0]  m_tuser,
	input  wire logic                  m_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [REG_W-1:0]      cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         result_count,
	output int                         zero_div_count,
	output int                         saturated_count,
	output int                         input_stall_cycles
);

	localparam int SENSOR_BYTES = 12;
	localparam int TIME_BYTES   = 4;
	localparam int TIME_FACTOR  = 50;
	localparam int REPORT_MAX   = 10;
	localparam longint LEVEL_MAX = (longint'(1) <<< (LEVEL_W - 1)) - 1;
	localparam longint LEVEL_MIN = -(longint'(1) <<< (LEVEL_W - 1));

	// one sensor result as it leaves the block
	typedef struct packed {
		logic [IDX_W-1:0]   sensor;
		logic [TIME_W-1:0]  t_first;
		logic [TIME_W-1:0]  t_second;
		logic [TIME_W-1:0]  t_third;
		logic [LEVEL_W-1:0] level;
		logic               div_err;
		logic               last;
	} sensor_level_t;

	// own copy of the block state and registers
	logic [BYTE_W-1:0]        sample_buf [BUF_BYTES];
	logic [SLOT_W-1:0]        frame_slot;
	logic                     assembling;
	logic [REG_W-1:0]         scale_val [SENSOR_COUNT];
	logic signed [REG_W-1:0]  offset_val [SENSOR_COUNT];

	sensor_level_t expected_levels [$];
	int errors;
	int seen;
	int zero_divs;
	int saturated;
	int stalls;

	// little-endian time word from the sample buffer, times fifty
	function automatic logic [TIME_W-1:0] sample_time(input int base);
		logic [RAW_W-1:0] raw;
		raw = {sample_buf[base + 3], sample_buf[base + 2], sample_buf[base + 1], sample_buf[base]};
		return TIME_W'(raw) * TIME_W'(TIME_FACTOR);
	endfunction

	// level of one sensor from the current buffer and registers
	function automatic sensor_level_t predict_sensor(input int n);
		sensor_level_t r;
		longint rise;
		longint fall;
		longint ratio;
		longint lvl;
		r.sensor   = IDX_W'(n);
		r.t_first  = sample_time(SENSOR_BYTES * n);
		r.t_second = sample_time(SENSOR_BYTES * n + TIME_BYTES);
		r.t_third  = sample_time(SENSOR_BYTES * n + 2 * TIME_BYTES);
		rise = longint'(r.t_second) - longint'(r.t_first);
		fall = longint'(r.t_third) - longint'(r.t_second);
		if (rise == 0) begin
			r.div_err = 1'b1;
			r.level   = '0;
		end else begin
			ratio = (longint'(scale_val[n]) * fall) / rise;
			lvl = longint'(offset_val[n]) - ratio;
			if (lvl > LEVEL_MAX)
				lvl = LEVEL_MAX;
			else if (lvl < LEVEL_MIN)
				lvl = LEVEL_MIN;
			r.div_err = 1'b0;
			r.level   = lvl[LEVEL_W-1:0];
		end
		r.last = (n == SENSOR_COUNT - 1);
		return r;
	endfunction

	// one field of a result against its expectation
	function automatic void check_field(input string what, input logic [63:0] want,
			input logic [63:0] got, input int n);
		if (want !== got) begin
			errors++;
			if (errors <= REPORT_MAX)
				$display("mismatch on %s of sensor %0d: expected %0h, got %0h", what, n, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : level_track
		sensor_level_t want;
		logic [CODE_W-1:0] code;
		int idx;
		if (!arst_n) begin
			for (int b = 0; b < BUF_BYTES; b++)
				sample_buf[b] = '0;
			for (int n = 0; n < SENSOR_COUNT; n++) begin
				scale_val[n]  = SCALE_RST[n];
				offset_val[n] = OFFSET_RST[n];
			end
			frame_slot = '0;
			assembling = 1'b0;
			expected_levels.delete();
			errors = 0;
			seen = 0;
			zero_divs = 0;
			saturated = 0;
			stalls = 0;
		end else begin
			// results leaving the block
			if (m_tvalid && m_tready) begin
				seen++;
				if (expected_levels.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("unexpected result: sensor %0d level %0h", m_tuser[IDX_W-1:0],
							m_tdata[3 * TIME_W +: LEVEL_W]);
				end else begin
					want = expected_levels.pop_front();
					check_field("sensor_index", want.sensor, m_tuser[IDX_W-1:0], want.sensor);
					check_field("time_first", want.t_first, m_tdata[0 +: TIME_W], want.sensor);
					check_field("time_second", want.t_second, m_tdata[TIME_W +: TIME_W], want.sensor);
					check_field("time_third", want.t_third, m_tdata[2 * TIME_W +: TIME_W],
						want.sensor);
					check_field("level", want.level, m_tdata[3 * TIME_W +: LEVEL_W], want.sensor);
					check_field("divide_error", want.div_err, m_tuser[IDX_W], want.sensor);
					check_field("last", want.last, m_tlast, want.sensor);
					if (want.div_err)
						zero_divs++;
					else if (want.level == LEVEL_W'(LEVEL_MAX) || want.level == LEVEL_W'(LEVEL_MIN))
						saturated++;
				end
			end

			// register writes
			if (cfg_we) begin
				if (cfg_index >= CFG_OFFSET0)
					offset_val[cfg_index - CFG_OFFSET0] = cfg_data;
				else if (cfg_index >= CFG_SCALE0)
					scale_val[cfg_index - CFG_SCALE0] = cfg_data;
			end

			// frames entering the block
			if (s_tvalid && !s_tready)
				stalls++;
			if (s_tvalid && s_tready) begin
				code = s_tdata[CODE_W-1:0];
				if (code == CODE_START) begin
					assembling = 1'b1;
					frame_slot = '0;
				end
				if (code >= CODE_START && code <= CODE_FINAL && assembling) begin
					for (int k = 0; k < DATA_PER_FRAME; k++) begin
						idx = int'(frame_slot) * DATA_PER_FRAME + k;
						if (idx < BUF_BYTES)
							sample_buf[idx] = s_tdata[CODE_W + BYTE_W * k +: BYTE_W];
					end
					if (frame_slot < SLOT_MAX)
						frame_slot = frame_slot + 1'b1;
					if (code == CODE_FINAL) begin
						for (int n = 0; n < SENSOR_COUNT; n++)
							expected_levels.push_back(predict_sensor(n));
					end
				end
			end
		end
		fail_count         <= errors;
		pending            <= expected_levels.size();
		result_count       <= seen;
		zero_div_count     <= zero_divs;
		saturated_count    <= saturated;
		input_stall_cycles <= stalls;
	end

endmodule

// ===== tb/frame_reassembly_tof_level_calc_top_test.sv =====
// testbench top for the level calculator: clock, reset, frame stimulus and verdict
`timescale 1ns / 1ps

module frame_reassembly_tof_level_calc_top_test import frtlc_pkg::*;;

	localparam int SENSOR_COUNT  = 3;
	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 4;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 250;
	localparam int LONG_STALL    = 700;
	localparam int IMAGE_BYTES   = 8 * DATA_PER_FRAME;
	localparam int SENSOR_BYTES  = 12;
	localparam int TIME_BYTES    = 4;
	localparam int PHASES        = 5;
	localparam int PHASE_MAX     = 0;
	localparam int PHASE_MIN     = 1;
	localparam int PHASE_PRESSED = 2;
	localparam int PHASE_FRAMES  = 32;
	localparam int SEQ_FRAMES    = 6;

	// frame codes beside start and final
	localparam logic [CODE_W-1:0] CODE_CONT_FIRST = CODE_START + 8'd1;
	localparam logic [CODE_W-1:0] CODE_CONT_LAST  = CODE_FINAL - 8'd1;
	localparam logic [CODE_W-1:0] CODE_BELOW      = CODE_START - 8'd1;
	localparam logic [CODE_W-1:0] CODE_ABOVE      = CODE_FINAL + 8'd1;
	localparam logic [CODE_W-1:0] CODE_ZERO       = 8'h00;
	localparam logic [CODE_W-1:0] CODE_ALL_ONES   = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic m_tlast;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;

	logic idling_on = 1'b0;
	logic stall_go = 1'b0;
	int stall_left = 0;
	int rx_idle_left = 0;
	int unsigned cycle_count = 0;
	int frames_sent = 0;
	int settings_done = 0;

	int fail_count;
	int pending;
	int result_count;
	int zero_div_count;
	int saturated_count;
	int input_stall_cycles;

	// payload bytes by position, sliced into frames of seven
	logic [BYTE_W-1:0] image [IMAGE_BYTES];

	always #(CLK_PERIOD / 2) clk = ~clk;

	frame_reassembly_tof_level_calc_top #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	frame_reassembly_tof_level_calc_checker #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.result_count(result_count),
		.zero_div_count(zero_div_count),
		.saturated_count(saturated_count),
		.input_stall_cycles(input_stall_cycles)
	);

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
		end else if (stall_go) begin
			stall_left <= LONG_STALL;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// receiver readiness with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_idle_left <= 0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
		end else if (rx_idle_left != 0) begin
			m_tready <= 1'b0;
			rx_idle_left <= rx_idle_left - 1;
		end else if (idling_on && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_idle_left <= $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
			$display("status: fail");
			$finish;
		end
	end

	// place one raw time word of one sensor into the image
	task automatic set_time(input int sensor, input int slot, input logic [RAW_W-1:0] raw);
		int base;
		base = SENSOR_BYTES * sensor + TIME_BYTES * slot;
		for (int b = 0; b < TIME_BYTES; b++)
			image[base + b] = raw[BYTE_W * b +: BYTE_W];
	endtask

	// random payload with time triples of assorted shapes
	task automatic make_image();
		logic [RAW_W-1:0] t1;
		logic [RAW_W-1:0] t2;
		logic [RAW_W-1:0] t3;
		for (int b = 0; b < IMAGE_BYTES; b++)
			image[b] = BYTE_W'($urandom);
		for (int n = 0; n < SENSOR_COUNT; n++) begin
			case ($urandom_range(0, 5))
				0: begin
					t1 = $urandom;
					t2 = $urandom;
					t3 = $urandom;
				end
				1: begin
					// equal first and second time
					t1 = $urandom;
					t2 = t1;
					t3 = $urandom;
				end
				2: begin
					// tiny divisor, level likely clips
					t1 = $urandom;
					t2 = t1 + RAW_W'($urandom_range(1, 16));
					t3 = $urandom;
				end
				3: begin
					t1 = $urandom_range(0, 32'h000F_FFFF) ? 32'hFFFF_FFFF : '0;
					t1 = $urandom_range(0, 1) ? 32'hFFFF_FFFF : '0;
					t2 = $urandom_range(0, 1) ? 32'hFFFF_FFFF : '0;
					t3 = $urandom_range(0, 1) ? 32'hFFFF_FFFF : '0;
				end
				default: begin
					// plausible echo timing
					t1 = $urandom_range(0, 32'h000F_FFFF);
					t2 = t1 + RAW_W'($urandom_range(1, 65535));
					t3 = t2 + RAW_W'($urandom_range(0, 65535));
				end
			endcase
			set_time(n, 0, t1);
			set_time(n, 1, t2);
			set_time(n, 2, t3);
		end
	endtask

	// offer one frame built from the image at a slot position
	task automatic put_frame(input logic [CODE_W-1:0] code, input int slot);
		logic [S_TDATA_W-1:0] payload;
		int idx;
		int k;
		payload = '0;
		payload[CODE_W-1:0] = code;
		for (k = 0; k < DATA_PER_FRAME; k++) begin
			idx = slot * DATA_PER_FRAME + k;
			payload[CODE_W + BYTE_W * k +: BYTE_W] = (idx < IMAGE_BYTES) ? image[idx] :
				BYTE_W'($urandom);
		end
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tdata <= payload;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (code >= CODE_START && code <= CODE_FINAL)
			frames_sent++;
	endtask

	// start frame, continuations, final frame
	task automatic send_sequence(input int frames);
		logic [CODE_W-1:0] code;
		for (int s = 0; s < frames; s++) begin
			if (s == 0)
				code = CODE_START;
			else if (s == frames - 1)
				code = CODE_FINAL;
			else if (CODE_START + s <= CODE_CONT_LAST)
				code = CODE_START + CODE_W'(s);
			else
				code = CODE_W'($urandom_range(CODE_CONT_FIRST, CODE_CONT_LAST));
			put_frame(code, s);
		end
	endtask

	// let every due result arrive and the sequencer settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int pick;
		int phase_start;
		logic [REG_W-1:0] scale_set;
		logic [REG_W-1:0] offset_set;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling_on <= 1'b1;

		// continuation and final before any start are ignored
		for (int b = 0; b < IMAGE_BYTES; b++)
			image[b] = '1;
		put_frame(CODE_CONT_FIRST, 0);
		put_frame(CODE_FINAL, 0);

		// codes outside the frame range
		put_frame(CODE_ZERO, 0);
		put_frame(CODE_BELOW, 1);
		for (int b = 0; b < IMAGE_BYTES; b++)
			image[b] = '0;
		put_frame(CODE_ALL_ONES, 0);
		put_frame(CODE_ABOVE, 1);

		// zero divisor, clip low, clip high
		make_image();
		set_time(0, 0, 32'h1234_5678);
		set_time(0, 1, 32'h1234_5678);
		set_time(0, 2, 32'hFFFF_FFFF);
		set_time(1, 0, 32'h0000_0000);
		set_time(1, 1, 32'h0000_0001);
		set_time(1, 2, 32'hFFFF_FFFF);
		set_time(2, 0, 32'hFFFF_FFFE);
		set_time(2, 1, 32'hFFFF_FFFF);
		set_time(2, 2, 32'h0000_0000);
		send_sequence(SEQ_FRAMES);

		// final right after a restart
		make_image();
		send_sequence(2);

		// slot runs past the buffer end and saturates
		make_image();
		send_sequence(10);
		drain();

		// register settings, extremes first
		for (int phase = 0; phase < PHASES; phase++) begin
			for (int n = 0; n < SENSOR_COUNT; n++) begin
				if (phase == PHASE_MAX) begin
					scale_set  = '1;
					offset_set = {1'b0, {(REG_W - 1){1'b1}}};
				end else if (phase == PHASE_MIN) begin
					scale_set  = '0;
					offset_set = {1'b1, {(REG_W - 1){1'b0}}};
				end else begin
					scale_set  = REG_W'($urandom);
					offset_set = REG_W'($urandom);
				end
				cfg_we <= 1'b1;
				cfg_index <= CFG_SCALE0 + CFG_IDX_W'(n);
				cfg_data <= scale_set;
				@(posedge clk);
				cfg_index <= CFG_OFFSET0 + CFG_IDX_W'(n);
				cfg_data <= offset_set;
				@(posedge clk);
			end
			cfg_we <= 1'b0;
			settings_done++;

			// output held off while frames keep coming
			if (phase == PHASE_PRESSED) begin
				idling_on <= 1'b0;
				stall_go <= 1'b1;
				@(posedge clk);
				stall_go <= 1'b0;
				make_image();
				send_sequence(SEQ_FRAMES);
				make_image();
				send_sequence(SEQ_FRAMES);
			end
			idling_on <= (phase != PHASES - 1);

			phase_start = frames_sent;
			while (frames_sent - phase_start < PHASE_FRAMES) begin
				pick = $urandom_range(0, 9);
				make_image();
				if (pick < 6) begin
					send_sequence(SEQ_FRAMES);
				end else if (pick == 6) begin
					// early final frame
					send_sequence($urandom_range(2, SEQ_FRAMES - 1));
				end else if (pick == 7) begin
					// overrun
					send_sequence($urandom_range(SEQ_FRAMES + 1, 11));
				end else if (pick == 8) begin
					put_frame(CODE_W'($urandom_range(0, 255)), $urandom_range(0, 7));
				end else begin
					// continuation or final with no fresh start
					put_frame(CODE_W'($urandom_range(CODE_CONT_FIRST, CODE_FINAL)),
						$urandom_range(0, 7));
				end
			end
			drain();
		end

		$display("sent %0d frames over %0d register settings, %0d input stall cycles",
			frames_sent, settings_done, input_stall_cycles);
		$display("checked %0d sensor results: %0d zero divisor, %0d clipped levels",
			result_count, zero_div_count, saturated_count);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, pending);
			$display("status: fail");
		end
		$finish;
	end

endmodule
